@@ sv/sfdg_pkg.sv @@
// Package for the smoothed fractional delay gain stage.
// Holds sizing constants, register indexes and shared types. No dependencies.
package sfdg_pkg;
  localparam int RING_DEPTH      = 4096;
  localparam int SAMPLE_BITS     = 24;
  localparam int DELAY_FRAC_BITS = 8;
  localparam int EXTRA_BITS      = 8;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 20;

  localparam logic [CFG_IDX_BITS-1:0] REG_MASTER_GAIN    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ATT_GAIN       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ATT_ENABLE     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_ACTIVE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_SAMPLES  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_ENABLE   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_LENGTH    = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SMOOTH_COEF    = 3'd7;

  typedef struct packed {
    logic [19:0] master_gain;
    logic [19:0] att_gain;
    logic        att_enable;
    logic        channel_active;
    logic [19:0] delay_samples;
    logic        delay_enable;
    logic [13:0] ramp_length;
    logic [15:0] smooth_coef;
  } cfg_t;
endpackage

@@ sv/sfdg_stream_if.sv @@
// Valid/ready stream interface carrying one sample word.
// Depends on no package.
interface sfdg_stream_if #(parameter int W = 24);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/smoothed_fractional_delay_gain.sv @@
// Smoothed fractional delay and gain stage for one audio channel.
// One word at a time: a new word is accepted only in the idle state, once the previous
// result is registered. A word that starts a delay move first waits for the ramp-step
// divider. In a move each word reads four ring taps, else one tap. An output register
// holds the previous word, so the next result waits only if that word is still unaccepted.
// Reset: synchronous, active low, then every ring entry is cleared with no word accepted.
module smoothed_fractional_delay_gain #(
  parameter int RING_DEPTH  = sfdg_pkg::RING_DEPTH,
  parameter int SAMPLE_BITS = sfdg_pkg::SAMPLE_BITS,
  parameter int DFB         = sfdg_pkg::DELAY_FRAC_BITS
) (
  input  logic clk,
  input  logic rst_n,
  sfdg_stream_if.sink   in_s,
  sfdg_stream_if.source out_s,
  input  logic                                   cfg_we,
  input  logic [sfdg_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [sfdg_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  localparam int AW  = $clog2(RING_DEPTH);
  localparam int FB  = DFB + sfdg_pkg::EXTRA_BITS;
  localparam int DLW = AW + FB + 1;          // delay width
  localparam int NW  = DLW + 1;              // signed diff width
  localparam int SW  = SAMPLE_BITS;
  localparam int CW  = SW + 6;               // cubic working width
  localparam int MW  = CW;                   // multiplier operand A width
  localparam int PW  = MW + 25;
  localparam logic [DLW-1:0] DMAX = DLW'(RING_DEPTH - 3) << DFB;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_DIV, S_GEOM, S_RD0, S_RD1, S_RD2, S_RD3, S_RD4,
    S_C3, S_C2, S_C1, S_GAIN, S_SMOOTH, S_OUT
  } state_t;

  sfdg_pkg::cfg_t cfg_r;
  state_t state_r;
  logic [AW-1:0]  wp_r, clr_r, addr;
  logic [DLW-1:0] cur_delay_r;
  logic [19:0]    cur_gain_r;
  logic signed [NW-1:0] ramp_step_r;
  logic [13:0]    ramp_left_r;
  logic           ramp_on_r;
  logic [SW-1:0]  sin_r;
  logic signed [SW-1:0] xm1_r, x0_r, x1_r, x2_r;
  logic signed [CW-1:0] rd_r;
  logic [FB:0]    fr_r;
  logic [AW-1:0]  base_r;
  logic signed [CW-1:0] t_r;
  logic [19:0]    g_r;
  logic [SW-1:0]  out_r;
  logic           out_v_r;

  logic           ram_we;
  logic [SW-1:0]  ram_wd, ram_rd;

  logic signed [MW-1:0] ma;
  logic signed [24:0]   mb;
  logic signed [PW-1:0] prod;
  assign prod = ma * mb;

  logic [DLW-1:0] target;
  logic [19:0]    dsat;
  logic [13:0]    len;
  assign dsat   = (DLW'(cfg_r.delay_samples) > DMAX) ? DMAX[19:0] : cfg_r.delay_samples;
  assign target = cfg_r.delay_enable ? (DLW'(dsat) << sfdg_pkg::EXTRA_BITS) : '0;
  assign len    = (cfg_r.ramp_length == '0) ? 14'd1 : cfg_r.ramp_length;

  logic div_start, div_done;
  logic signed [NW-1:0] div_q;
  sfdg_divider #(.NW(NW), .DW(14)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num($signed({1'b0, target}) - $signed({1'b0, cur_delay_r})),
    .den(len), .done(div_done), .quo(div_q)
  );

  sfdg_ram #(.WIDTH(SW), .DEPTH(RING_DEPTH)) u_ring (
    .clk(clk), .we(ram_we), .addr(addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  // next delay during a move
  logic [DLW-1:0] nd;
  logic [DLW-1:0] rnd;
  logic [AW-1:0]  ip;
  logic [FB-1:0]  fpart;
  assign nd    = (ramp_left_r == 14'd1) ? target :
                 DLW'($signed({1'b0, cur_delay_r}) + ramp_step_r);
  assign ip    = nd[FB +: AW];
  assign fpart = nd[FB-1:0];
  assign rnd   = cur_delay_r + (DLW'(1) << (FB - 1));

  // cubic coefficients
  logic signed [CW-1:0] c1, c2, c3;
  assign c1 = CW'(x1_r) - CW'(xm1_r);
  assign c2 = CW'(4) * CW'(x1_r) + CW'(2) * CW'(xm1_r) - CW'(5) * CW'(x0_r) - CW'(x2_r);
  assign c3 = CW'(3) * (CW'(x0_r) - CW'(x1_r)) - CW'(xm1_r) + CW'(x2_r);

  logic [39:0] gprod;
  assign gprod = prod[39:0];

  always_comb begin
    ma = '0;
    mb = '0;
    ram_we = 1'b0;
    ram_wd = sin_r;
    addr = wp_r;
    unique case (state_r)
      S_CLEAR: begin ram_we = 1'b1; ram_wd = '0; addr = clr_r; end
      S_WRITE: ram_we = 1'b1;
      S_RD0:   addr = ramp_on_r ? AW'(base_r - 1'b1) : base_r;
      S_RD1:   addr = base_r;
      S_RD2:   addr = AW'(base_r + 1'b1);
      S_RD3:   addr = AW'(base_r + 2'd2);
      S_C3:    begin ma = c3; mb = 25'($signed({1'b0, fr_r})); end
      S_C2:    begin ma = t_r; mb = 25'($signed({1'b0, fr_r})); end
      S_C1:    begin ma = t_r; mb = 25'($signed({1'b0, fr_r})); end
      S_GAIN:  begin
        ma = MW'($signed({1'b0, cfg_r.master_gain}));
        mb = cfg_r.att_enable ? 25'($signed({1'b0, cfg_r.att_gain})) : 25'sd65536;
      end
      S_SMOOTH: begin
        ma = MW'($signed({1'b0, g_r}) - $signed({1'b0, cur_gain_r}));
        mb = 25'($signed({1'b0, cfg_r.smooth_coef}));
      end
      S_OUT:   begin ma = rd_r; mb = 25'($signed({1'b0, cur_gain_r})); end
      default: ;
    endcase
  end

  logic signed [PW-1:0] yv;
  assign yv = prod >>> 16;
  logic signed [PW-1:0] sm;
  assign sm = (prod + PW'(32768)) >>> 16;

  logic out_free;
  assign out_free = !out_v_r || out_s.ready;

  assign div_start   = (state_r == S_WRITE) && (ramp_left_r == '0) && (target != cur_delay_r);
  assign in_s.ready  = (state_r == S_IDLE);
  assign out_s.valid = out_v_r;
  assign out_s.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      wp_r        <= '0;
      cur_delay_r <= '0;
      cur_gain_r  <= '0;
      ramp_step_r <= '0;
      ramp_left_r <= '0;
      ramp_on_r   <= 1'b0;
      out_v_r     <= 1'b0;
      cfg_r       <= '{master_gain: 20'd65536, att_gain: 20'd65536, att_enable: 1'b0,
                       channel_active: 1'b1, delay_samples: '0, delay_enable: 1'b0,
                       ramp_length: 14'd256, smooth_coef: 16'd1792};
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sfdg_pkg::REG_MASTER_GAIN:    cfg_r.master_gain    <= cfg_data[19:0];
          sfdg_pkg::REG_ATT_GAIN:       cfg_r.att_gain       <= cfg_data[19:0];
          sfdg_pkg::REG_ATT_ENABLE:     cfg_r.att_enable     <= cfg_data[0];
          sfdg_pkg::REG_CHANNEL_ACTIVE: cfg_r.channel_active <= cfg_data[0];
          sfdg_pkg::REG_DELAY_SAMPLES:  cfg_r.delay_samples  <= cfg_data[19:0];
          sfdg_pkg::REG_DELAY_ENABLE:   cfg_r.delay_enable   <= cfg_data[0];
          sfdg_pkg::REG_RAMP_LENGTH:    cfg_r.ramp_length    <= cfg_data[13:0];
          sfdg_pkg::REG_SMOOTH_COEF:    cfg_r.smooth_coef    <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (state_r == S_OUT && out_free) out_v_r <= 1'b1;
      else if (out_s.ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(RING_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_s.valid) begin
          sin_r   <= in_s.data;
          state_r <= S_WRITE;
        end
        S_WRITE: state_r <= div_start ? S_DIV : S_GEOM;
        S_DIV: if (div_done) begin
          ramp_step_r <= div_q;
          ramp_left_r <= len;
          state_r     <= S_GEOM;
        end
        S_GEOM: begin
          if (ramp_left_r != '0) begin
            cur_delay_r <= nd;
            ramp_left_r <= ramp_left_r - 14'd1;
            ramp_on_r   <= 1'b1;
            if (fpart == '0) begin
              base_r <= wp_r - ip;
              fr_r   <= '0;
            end else begin
              base_r <= wp_r - ip - 1'b1;
              fr_r   <= {1'b1, {FB{1'b0}}} - {1'b0, fpart};
            end
          end else begin
            ramp_on_r <= 1'b0;
            base_r    <= wp_r - rnd[FB +: AW];
          end
          state_r <= S_RD0;
        end
        S_RD0: begin
          state_r <= S_RD1;
        end
        S_RD1: begin
          if (!ramp_on_r) begin
            x0_r    <= ram_rd;
            state_r <= S_GAIN;
          end else begin
            xm1_r   <= ram_rd;
            state_r <= S_RD2;
          end
        end
        S_RD2: begin x0_r <= ram_rd; state_r <= S_RD3; end
        S_RD3: begin x1_r <= ram_rd; state_r <= S_RD4; end
        S_RD4: begin x2_r <= ram_rd; state_r <= S_C3; end
        S_C3: begin
          t_r <= CW'(c2 + CW'(prod >>> FB));
          state_r <= S_C2;
        end
        S_C2: begin
          t_r <= CW'(c1 + CW'(prod >>> FB));
          state_r <= S_C1;
        end
        S_C1: begin
          rd_r <= CW'(CW'(x0_r) + CW'(prod >>> (FB + 1)));
          state_r <= S_GAIN;
        end
        S_GAIN: begin
          if (!ramp_on_r) rd_r <= CW'(x0_r);
          if (!cfg_r.channel_active) g_r <= '0;
          else g_r <= (gprod[39:16] > 24'hFFFFF) ? 20'hFFFFF : gprod[35:16];
          state_r <= S_SMOOTH;
        end
        S_SMOOTH: begin
          cur_gain_r <= 20'($signed({1'b0, cur_gain_r}) + sm[21:0]);
          state_r <= S_OUT;
        end
        S_OUT: if (out_free) begin
          if (yv > PW'(2 ** (SW - 1) - 1))     out_r <= {1'b0, {(SW-1){1'b1}}};
          else if (yv < -PW'(2 ** (SW - 1)))   out_r <= {1'b1, {(SW-1){1'b0}}};
          else                                 out_r <= yv[SW-1:0];
          wp_r    <= wp_r + 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_s.ready) |=> (out_v_r && $stable(out_r)))
    else $error("result word dropped or changed while waiting");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> out_v_r)
    else $error("result word lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_s.ready)
    else $error("accept during clear");
endmodule

@@ sv/sfdg_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module sfdg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ sv/sfdg_divider.sv @@
// Restoring divider, one quotient bit per cycle, signed dividend, unsigned divisor.
// Quotient truncates toward zero. Depends on no package.
module sfdg_divider #(
  parameter int NW = 30,
  parameter int DW = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic [DW-1:0]        den,
  output logic                 done,
  output logic signed [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0]  mag_r, q_r;
  logic [DW:0]    rem_r;
  logic [DW-1:0]  den_r;
  logic           neg_r, busy_r;
  logic [CW-1:0]  cnt_r;
  logic [DW:0]    trial;
  logic [DW:0]    shifted;

  assign shifted = {rem_r[DW-1:0], mag_r[NW-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign done    = busy_r && (cnt_r == '0);
  assign quo     = neg_r ? -$signed(q_r) : $signed(q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
      neg_r  <= num[NW-1];
      mag_r  <= num[NW-1] ? NW'(-num) : NW'(num);
      rem_r  <= '0;
      q_r    <= '0;
      den_r  <= den;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
        mag_r <= {mag_r[NW-2:0], 1'b0};
        if (!trial[DW]) begin
          rem_r <= trial;
          q_r   <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= shifted;
          q_r   <= {q_r[NW-2:0], 1'b0};
        end
      end
    end
  end
endmodule

@@ verif/tb_smoothed_fractional_delay_gain.sv @@
// Testbench for smoothed_fractional_delay_gain: directed and random words over many
// register settings, checked against a cycle-free predictor in a scoreboard class.
// Depends on sfdg_pkg, sfdg_stream_if and the block itself.
`timescale 1ns / 1ps

module tb_smoothed_fractional_delay_gain;
  localparam int SB = sfdg_pkg::SAMPLE_BITS;
  localparam int IB = sfdg_pkg::CFG_IDX_BITS;
  localparam int DB = sfdg_pkg::CFG_DATA_BITS;
  localparam longint DELAY_MAX =
    longint'(sfdg_pkg::RING_DEPTH - 3) << sfdg_pkg::DELAY_FRAC_BITS;
  localparam int FRAC_W = sfdg_pkg::DELAY_FRAC_BITS + sfdg_pkg::EXTRA_BITS;
  localparam longint RING_MASK = sfdg_pkg::RING_DEPTH - 1;
  localparam longint SAMPLE_MAX = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  class gained_sample_tracker;
    longint ring[sfdg_pkg::RING_DEPTH];
    longint wpos, cur_delay, cur_gain, ramp_left, ramp_step;
    longint regs[8];
    logic [SB-1:0] expected_q[$];
    int mismatches;

    function new();
      foreach (ring[i]) ring[i] = 0;
      wpos = 0; cur_delay = 0; cur_gain = 0; ramp_left = 0; ramp_step = 0;
      regs[sfdg_pkg::REG_MASTER_GAIN] = 65536;
      regs[sfdg_pkg::REG_ATT_GAIN] = 65536;
      regs[sfdg_pkg::REG_ATT_ENABLE] = 0;
      regs[sfdg_pkg::REG_CHANNEL_ACTIVE] = 1;
      regs[sfdg_pkg::REG_DELAY_SAMPLES] = 0;
      regs[sfdg_pkg::REG_DELAY_ENABLE] = 0;
      regs[sfdg_pkg::REG_RAMP_LENGTH] = 256;
      regs[sfdg_pkg::REG_SMOOTH_COEF] = 1792;
      mismatches = 0;
    endfunction

    function void write_reg(logic [IB-1:0] idx, longint v);
      case (idx)
        sfdg_pkg::REG_MASTER_GAIN, sfdg_pkg::REG_ATT_GAIN, sfdg_pkg::REG_DELAY_SAMPLES:
          regs[idx] = v & 20'hFFFFF;
        sfdg_pkg::REG_ATT_ENABLE, sfdg_pkg::REG_CHANNEL_ACTIVE, sfdg_pkg::REG_DELAY_ENABLE:
          regs[idx] = v & 1;
        sfdg_pkg::REG_RAMP_LENGTH: regs[idx] = v & 14'h3FFF;
        default: regs[idx] = v & 16'hFFFF;
      endcase
    endfunction

    function longint tap(longint idx);
      return ring[idx & RING_MASK];
    endfunction

    function void note_sample(logic [SB-1:0] s);
      longint tgt, len, g, rd, y, ip, f, base, fr, xm1, x0, x1, x2, c1, c2, c3, t;
      ring[wpos] = longint'($signed(s));
      tgt = 0;
      if (regs[sfdg_pkg::REG_DELAY_ENABLE] != 0)
        tgt = (regs[sfdg_pkg::REG_DELAY_SAMPLES] > DELAY_MAX ? DELAY_MAX :
               regs[sfdg_pkg::REG_DELAY_SAMPLES]) << sfdg_pkg::EXTRA_BITS;
      len = regs[sfdg_pkg::REG_RAMP_LENGTH] == 0 ? 1 : regs[sfdg_pkg::REG_RAMP_LENGTH];
      if (ramp_left == 0 && tgt != cur_delay) begin
        ramp_step = (tgt - cur_delay) / len;
        ramp_left = len;
      end
      if (ramp_left > 0) begin
        cur_delay = cur_delay + ramp_step;
        ramp_left--;
        if (ramp_left == 0) cur_delay = tgt;
        ip = cur_delay >> FRAC_W;
        f = cur_delay & ((64'sd1 <<< FRAC_W) - 1);
        if (f == 0) begin
          base = wpos - ip;
          fr = 0;
        end else begin
          base = wpos - ip - 1;
          fr = (64'sd1 <<< FRAC_W) - f;
        end
        xm1 = tap(base - 1); x0 = tap(base); x1 = tap(base + 1); x2 = tap(base + 2);
        c1 = x1 - xm1;
        c2 = 4 * x1 + 2 * xm1 - 5 * x0 - x2;
        c3 = 3 * (x0 - x1) - xm1 + x2;
        t = c2 + ((c3 * fr) >>> FRAC_W);
        t = c1 + ((t * fr) >>> FRAC_W);
        rd = x0 + ((t * fr) >>> (FRAC_W + 1));
      end else begin
        rd = tap(wpos - ((cur_delay + (64'sd1 <<< (FRAC_W - 1))) >> FRAC_W));
      end
      g = 0;
      if (regs[sfdg_pkg::REG_CHANNEL_ACTIVE] != 0) begin
        g = (regs[sfdg_pkg::REG_MASTER_GAIN] *
             (regs[sfdg_pkg::REG_ATT_ENABLE] != 0 ? regs[sfdg_pkg::REG_ATT_GAIN] : 65536))
            >> 16;
        if (g > 1048575) g = 1048575;
      end
      cur_gain = cur_gain +
                 (((g - cur_gain) * regs[sfdg_pkg::REG_SMOOTH_COEF] + 32768) >>> 16);
      y = (rd * cur_gain) >>> 16;
      if (y > SAMPLE_MAX) y = SAMPLE_MAX;
      if (y < SAMPLE_MIN) y = SAMPLE_MIN;
      expected_q.push_back(y[SB-1:0]);
      wpos = (wpos + 1) & RING_MASK;
    endfunction

    function void check_sample(logic [SB-1:0] got);
      logic [SB-1:0] want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        $display("%0t: sample_out mismatch, expected %h, actual %h", $time, want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [IB-1:0] cfg_index;
  logic [DB-1:0] cfg_data;
  sfdg_stream_if #(.W(SB)) in_s ();
  sfdg_stream_if #(.W(SB)) out_s ();

  gained_sample_tracker tracker = new();
  bit quiet;
  bit hold_req;
  int idle_cycles;

  smoothed_fractional_delay_gain u_top (
    .clk(clk), .rst_n(rst_n), .in_s(in_s), .out_s(out_s),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_s.valid = 1'b0;
    in_s.data = '0;
    out_s.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (out_s.valid && out_s.ready) tracker.check_sample(out_s.data);
  end

  always @(posedge clk) begin
    if ((in_s.valid && in_s.ready) || (out_s.valid && out_s.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 20000) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int stall;
    forever begin
      if (hold_req) begin
        out_s.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end
      stall = quiet ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_s.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_s.ready <= 1'b1;
      do @(posedge clk); while (!(out_s.valid && out_s.ready));
    end
  end

  task automatic write_reg(logic [IB-1:0] idx, logic [DB-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(idx, longint'(v));
  endtask

  task automatic send_word(logic [SB-1:0] w);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_s.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_s.valid <= 1'b1;
    in_s.data <= w;
    do @(posedge clk); while (!in_s.ready);
    tracker.note_sample(w);
  endtask

  task automatic drain();
    in_s.valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [SB-1:0] rand_sample();
    case ($urandom_range(0, 15))
      0: return {1'b1, {(SB-1){1'b0}}};
      1: return {1'b0, {(SB-1){1'b1}}};
      2: return '0;
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic [19:0] rand_gain();
    case ($urandom_range(0, 7))
      0: return 20'd0;
      1: return 20'hFFFFF;
      2: return 20'd65536;
      default: return 20'($urandom_range(0, 200000));
    endcase
  endfunction

  task automatic random_settings();
    int sel;
    write_reg(sfdg_pkg::REG_MASTER_GAIN, rand_gain());
    write_reg(sfdg_pkg::REG_ATT_GAIN, rand_gain());
    write_reg(sfdg_pkg::REG_ATT_ENABLE, DB'($urandom_range(0, 1)));
    write_reg(sfdg_pkg::REG_CHANNEL_ACTIVE, DB'($urandom_range(0, 5) != 0));
    sel = $urandom_range(0, 9);
    write_reg(sfdg_pkg::REG_DELAY_SAMPLES, DB'(sel == 0 ? 32'hFFFFF : sel == 1 ? 1047808 :
              sel < 4 ? $urandom_range(0, 511) : $urandom_range(0, 64 * 256)));
    write_reg(sfdg_pkg::REG_DELAY_ENABLE, DB'($urandom_range(0, 4) != 0));
    sel = $urandom_range(0, 9);
    write_reg(sfdg_pkg::REG_RAMP_LENGTH, DB'(sel == 0 ? 0 : sel == 1 ? 8192 :
              sel == 2 ? 16383 : $urandom_range(1, 64)));
    sel = $urandom_range(0, 7);
    write_reg(sfdg_pkg::REG_SMOOTH_COEF, DB'(sel == 0 ? 0 : sel == 1 ? 32'hFFFF :
              $urandom_range(1, 8000)));
  endtask

  initial begin
    idle_cycles = 0;
    quiet = 0;
    hold_req = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word({1'b1, {(SB-1){1'b0}}});
    send_word({1'b0, {(SB-1){1'b1}}});
    send_word('0);
    send_word('1);
    drain();
    write_reg(sfdg_pkg::REG_SMOOTH_COEF, 20'hFFFF);
    write_reg(sfdg_pkg::REG_MASTER_GAIN, 20'hFFFFF);
    write_reg(sfdg_pkg::REG_ATT_GAIN, 20'hFFFFF);
    write_reg(sfdg_pkg::REG_ATT_ENABLE, 20'd1);
    write_reg(sfdg_pkg::REG_DELAY_SAMPLES, 20'd640);
    write_reg(sfdg_pkg::REG_DELAY_ENABLE, 20'd1);
    write_reg(sfdg_pkg::REG_RAMP_LENGTH, 20'd4);
    for (int i = 0; i < 8; i++) send_word(rand_sample());
    drain();
    write_reg(sfdg_pkg::REG_DELAY_SAMPLES, 20'd0);
    write_reg(sfdg_pkg::REG_RAMP_LENGTH, 20'd0);
    write_reg(sfdg_pkg::REG_CHANNEL_ACTIVE, 20'd0);
    for (int i = 0; i < 4; i++) send_word(rand_sample());
    drain();
    write_reg(sfdg_pkg::REG_CHANNEL_ACTIVE, 20'd1);
    write_reg(sfdg_pkg::REG_RAMP_LENGTH, 20'd300);
    write_reg(sfdg_pkg::REG_DELAY_SAMPLES, 20'hFFFFF);
    for (int i = 0; i < 4; i++) send_word(rand_sample());
    drain();
    write_reg(sfdg_pkg::REG_DELAY_SAMPLES, 20'd100);
    for (int i = 0; i < 4; i++) send_word(rand_sample());
    drain();

    for (int p = 0; p < 10; p++) begin
      random_settings();
      quiet = (p % 4 == 3);
      for (int i = 0; i < 120; i++) begin
        if (p == 2 && i == 10) hold_req = 1;
        send_word(rand_sample());
      end
      drain();
    end

    if (tracker.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ sim.f @@
sv/sfdg_pkg.sv
sv/sfdg_stream_if.sv
sv/sfdg_ram.sv
sv/sfdg_divider.sv
sv/smoothed_fractional_delay_gain.sv
verif/tb_smoothed_fractional_delay_gain.sv
